// ===== hdl/ddc_ci_vcp_i2c_master_macros.svh =====
// Assertion macros used by the engine module
`ifndef DDC_CI_VCP_I2C_MASTER_MACROS_SVH
`define DDC_CI_VCP_I2C_MASTER_MACROS_SVH

// Implication checked at every clock edge outside reset
`define DDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication with the consequent checked in the cycle after the antecedent
`define DDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/ddc_pkg.sv =====
package ddc_pkg;

    typedef enum logic [3:0] {
        P_IDLE, P_ST_A, P_ST_B, P_ST_C, P_B_LO, P_B_HI, P_SP_A, P_SP_B,
        P_SP_C, P_GAP, P_CL_CHK, P_CL_LO, P_CL_HI
    } t_phase;

    typedef enum logic [3:0] {
        S_NONE, S_SEND, S_RADDR, S_READ, F_SENT, F_NOACK, F_ADDRNACK,
        F_RECVD, F_CLEARED, G_RECV, G_DONE, G_RETRY
    } t_stage;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_NOACK = 2'd1, ST_FAILED = 2'd2, ST_CHKSUM = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        M_TICK = 2'd0, M_GET = 2'd1, M_SET = 2'd2, M_UNUSED = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_STRETCH = 2'd0, CFG_GAP = 2'd1, CFG_ATTEMPTS = 2'd2, CFG_NONE = 2'd3
    } t_cfg_idx;

    localparam logic [7:0] ADDR_WR     = 8'h6E;
    localparam logic [7:0] ADDR_RD     = 8'h6F;
    localparam logic [7:0] SRC_HOST    = 8'h51;
    localparam logic [7:0] CHK_SEED    = 8'h50;
    localparam logic [7:0] LEN_MASK    = 8'h7F;
    localparam logic [7:0] OP_GET_RPL  = 8'h02;
    localparam logic [7:0] OP_GET_REQ  = 8'h01;
    localparam logic [7:0] OP_SET_REQ  = 8'h03;
    localparam logic [7:0] LEN_GET_REQ = 8'h82;
    localparam logic [7:0] LEN_SET_REQ = 8'h84;
    localparam logic [7:0] TYPE_MOMENT = 8'h01;
    localparam int unsigned MIN_REPLY  = 11;

    typedef struct packed {
        logic [1:0]  mode;
        logic        scl;
        logic        sda;
        logic [7:0]  code;
        logic [15:0] value;
    } t_tick;

    typedef struct packed {
        logic        mom;
        logic [15:0] maxv;
        logic [15:0] cur;
        logic [1:0]  status;
    } t_result;

    typedef struct packed {
        logic        scl_low;
        logic        sda_low;
        logic        busy;
        logic        done;
        t_result     res;
    } t_out;

endpackage

// ===== hdl/ddc_cfg_regs.sv =====
module ddc_cfg_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic [15:0] o_stretch_limit,
    output logic [15:0] o_gap_ticks,
    output logic [2:0]  o_max_attempts
);
    logic [15:0] r_stretch;
    logic [15:0] r_gap;
    logic [2:0]  r_att;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stretch <= 16'd400;
            r_gap     <= 16'd200;
            r_att     <= 3'd3;
        end else if (i_cfg_valid) begin
            case (ddc_pkg::t_cfg_idx'(i_cfg_index))
                ddc_pkg::CFG_STRETCH:  r_stretch <= i_cfg_data;
                ddc_pkg::CFG_GAP:      r_gap     <= i_cfg_data;
                ddc_pkg::CFG_ATTEMPTS: r_att     <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign o_stretch_limit = r_stretch;
    assign o_gap_ticks     = r_gap;
    assign o_max_attempts  = r_att;
endmodule

// ===== hdl/ddc_engine.sv =====
`include "ddc_ci_vcp_i2c_master_macros.svh"
module ddc_engine #(
    parameter int unsigned REPLY_BYTES  = 16,
    parameter int unsigned CLEAR_PULSES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  ddc_pkg::t_tick   i_tick,
    input  logic [15:0]      i_stretch_limit,
    input  logic [15:0]      i_gap_ticks,
    input  logic [2:0]       i_max_attempts,
    output ddc_pkg::t_out    o_out
);
    localparam int unsigned RW = $clog2(REPLY_BYTES);
    localparam int unsigned CW = $clog2(CLEAR_PULSES + 1);

    ddc_pkg::t_phase r_phase, n_phase;
    ddc_pkg::t_stage r_stage, n_stage;
    logic [3:0]  r_bit, n_bit;
    logic [7:0]  r_idx, n_idx;
    logic [7:0]  r_shift, n_shift;
    logic [15:0] r_wait, n_wait;
    logic [2:0]  r_att, n_att;
    logic [7:0]  r_chk, n_chk;
    logic [6:0]  r_rlen, n_rlen;
    logic        r_is_set, n_is_set;
    logic [7:0]  r_code, n_code;
    logic [15:0] r_val, n_val;
    logic [CW-1:0] r_clr, n_clr;
    ddc_pkg::t_result r_res, n_res;
    logic        n_done;
    logic [7:0]  r_store [REPLY_BYTES];
    logic [7:0]  r_len_byte;
    logic        store_we;
    logic [RW-1:0] store_wa;
    logic [7:0]  n_len_byte;

    // per-tick combinational step
    always_comb begin
        logic [7:0] req_len, b, rb, bnew;
        logic last, nack;
        n_phase = r_phase; n_stage = r_stage; n_bit = r_bit; n_idx = r_idx;
        n_shift = r_shift; n_wait = r_wait; n_att = r_att; n_chk = r_chk;
        n_rlen = r_rlen; n_is_set = r_is_set; n_code = r_code; n_val = r_val;
        n_clr = r_clr; n_res = r_res; n_done = 1'b0;
        store_we = 1'b0; store_wa = r_idx[RW-1:0]; n_len_byte = r_len_byte;
        req_len = r_is_set ? 8'd8 : 8'd6;
        last = (r_idx >= 8'd2) && (r_idx == {1'b0, r_len_byte[6:0]} + 8'd2);
        nack = i_tick.sda;
        b = 8'hFF; rb = 8'h00; bnew = 8'h00;
        case (r_phase)
            ddc_pkg::P_IDLE: begin
                if (i_tick.mode == ddc_pkg::M_GET || i_tick.mode == ddc_pkg::M_SET) begin
                    n_is_set = (i_tick.mode == ddc_pkg::M_SET);
                    n_code = i_tick.code; n_val = i_tick.value; n_att = 3'd1;
                    n_stage = ddc_pkg::S_SEND; n_idx = '0; n_chk = '0;
                    n_phase = ddc_pkg::P_ST_A; n_wait = '0;
                end
            end
            ddc_pkg::P_ST_A: begin
                if (i_tick.scl) n_phase = ddc_pkg::P_ST_B;
                else if (r_wait >= i_stretch_limit) begin
                    n_stage = ddc_pkg::F_CLEARED; n_clr = '0; n_phase = ddc_pkg::P_CL_CHK;
                end else n_wait = r_wait + 16'd1;
            end
            ddc_pkg::P_ST_B: n_phase = ddc_pkg::P_ST_C;
            ddc_pkg::P_B_LO: begin n_phase = ddc_pkg::P_B_HI; n_wait = '0; end
            ddc_pkg::P_B_HI: begin
                if (!i_tick.scl) begin
                    if (r_wait >= i_stretch_limit) begin
                        n_stage = ddc_pkg::F_CLEARED; n_clr = '0;
                        n_phase = ddc_pkg::P_CL_CHK;
                    end else n_wait = r_wait + 16'd1;
                end else if (r_bit < 4'd8) begin
                    n_shift = {r_shift[6:0], i_tick.sda};
                    n_bit = r_bit + 4'd1; n_phase = ddc_pkg::P_B_LO;
                end else if (r_stage == ddc_pkg::S_SEND) begin
                    if (nack) begin n_stage = ddc_pkg::F_NOACK; n_phase = ddc_pkg::P_SP_A; end
                    else begin
                        n_idx = r_idx + 8'd1;
                        if (n_idx >= req_len) begin
                            n_stage = ddc_pkg::F_SENT; n_phase = ddc_pkg::P_SP_A;
                        end
                    end
                end else if (r_stage == ddc_pkg::S_RADDR) begin
                    if (nack) begin
                        n_stage = ddc_pkg::F_ADDRNACK; n_phase = ddc_pkg::P_SP_A;
                    end else begin
                        n_stage = ddc_pkg::S_READ; n_idx = '0; n_rlen = '0;
                        n_chk = ddc_pkg::CHK_SEED;
                    end
                end else begin
                    if (r_idx < 8'(REPLY_BYTES)) begin
                        store_we = 1'b1;
                        n_rlen = 7'(r_idx + 8'd1);
                        if (r_idx == 8'd1) n_len_byte = r_shift;
                    end
                    n_chk = r_chk ^ r_shift;
                    if (r_idx != 8'd255) n_idx = r_idx + 8'd1;
                    if (last) begin n_stage = ddc_pkg::F_RECVD; n_phase = ddc_pkg::P_SP_A; end
                end
            end
            ddc_pkg::P_SP_A: begin n_phase = ddc_pkg::P_SP_B; n_wait = '0; end
            ddc_pkg::P_SP_B: begin
                if (i_tick.scl || r_wait >= i_stretch_limit) n_phase = ddc_pkg::P_SP_C;
                else n_wait = r_wait + 16'd1;
            end
            ddc_pkg::P_SP_C: begin
                case (r_stage)
                    ddc_pkg::F_SENT: begin
                        n_stage = r_is_set ? ddc_pkg::G_DONE : ddc_pkg::G_RECV;
                        n_phase = ddc_pkg::P_GAP; n_wait = '0;
                    end
                    ddc_pkg::F_NOACK: begin
                        n_res = '{mom: 1'b0, maxv: '0, cur: '0, status: ddc_pkg::ST_NOACK};
                        n_done = 1'b1;
                    end
                    ddc_pkg::F_ADDRNACK: begin
                        n_stage = ddc_pkg::G_RETRY; n_phase = ddc_pkg::P_GAP; n_wait = '0;
                    end
                    ddc_pkg::F_RECVD: begin
                        if ((r_store[1] & ddc_pkg::LEN_MASK) == 8'd0 ||
                            r_rlen < 7'(ddc_pkg::MIN_REPLY) ||
                            r_store[0] != ddc_pkg::ADDR_WR ||
                            r_store[2] != ddc_pkg::OP_GET_RPL) begin
                            n_stage = ddc_pkg::G_RETRY; n_phase = ddc_pkg::P_GAP; n_wait = '0;
                        end else if (r_store[3] != 8'd0) begin
                            n_res = '{mom: 1'b0, maxv: '0, cur: '0,
                                      status: ddc_pkg::ST_FAILED};
                            n_done = 1'b1;
                        end else if (r_store[4] != r_code) begin
                            n_stage = ddc_pkg::G_RETRY; n_phase = ddc_pkg::P_GAP; n_wait = '0;
                        end else begin
                            n_res.status = (r_chk == 8'd0) ? ddc_pkg::ST_OK
                                                           : ddc_pkg::ST_CHKSUM;
                            n_res.cur  = {r_store[8], r_store[9]};
                            n_res.maxv = {r_store[6], r_store[7]};
                            n_res.mom  = (r_store[5] == ddc_pkg::TYPE_MOMENT);
                            n_done = 1'b1;
                        end
                    end
                    default: begin
                        if (r_is_set) begin
                            n_res = '{mom: 1'b0, maxv: '0, cur: '0,
                                      status: ddc_pkg::ST_FAILED};
                            n_done = 1'b1;
                        end else begin
                            n_stage = ddc_pkg::G_RETRY; n_phase = ddc_pkg::P_GAP;
                            n_wait = '0;
                        end
                    end
                endcase
            end
            ddc_pkg::P_GAP: begin
                if (r_wait < i_gap_ticks) n_wait = r_wait + 16'd1;
                else if (r_stage == ddc_pkg::G_RECV) begin
                    n_stage = ddc_pkg::S_RADDR; n_idx = '0; n_chk = '0;
                    n_phase = ddc_pkg::P_ST_A; n_wait = '0;
                end else if (r_stage == ddc_pkg::G_DONE) begin
                    n_res = '{mom: 1'b0, maxv: '0, cur: '0, status: ddc_pkg::ST_OK};
                    n_done = 1'b1;
                end else if (r_att >= i_max_attempts) begin
                    n_res = '{mom: 1'b0, maxv: '0, cur: '0, status: ddc_pkg::ST_FAILED};
                    n_done = 1'b1;
                end else begin
                    n_att = r_att + 3'd1;
                    n_stage = ddc_pkg::S_SEND; n_idx = '0; n_chk = '0;
                    n_phase = ddc_pkg::P_ST_A; n_wait = '0;
                end
            end
            ddc_pkg::P_CL_LO: begin n_phase = ddc_pkg::P_CL_HI; n_wait = '0; end
            ddc_pkg::P_CL_HI: begin
                if (!i_tick.scl) begin
                    if (r_wait >= i_stretch_limit) begin
                        n_stage = ddc_pkg::F_CLEARED; n_phase = ddc_pkg::P_SP_A;
                    end else n_wait = r_wait + 16'd1;
                end
            end
            default: ;
        endcase
        // bus-clear pulse check, shared by both entry phases
        if (r_phase == ddc_pkg::P_CL_CHK ||
            (r_phase == ddc_pkg::P_CL_HI && i_tick.scl)) begin
            if (i_tick.sda || r_clr >= CW'(CLEAR_PULSES)) begin
                n_stage = ddc_pkg::F_CLEARED; n_phase = ddc_pkg::P_SP_A;
            end else begin
                n_clr = r_clr + CW'(1); n_phase = ddc_pkg::P_CL_LO;
            end
        end
        // byte load, from start or after a byte that continues
        if (r_phase == ddc_pkg::P_ST_C ||
            (r_phase == ddc_pkg::P_B_HI && i_tick.scl && r_bit >= 4'd8 &&
             n_phase == ddc_pkg::P_B_HI)) begin
            case (n_idx)
                8'd0: rb = ddc_pkg::ADDR_WR;
                8'd1: rb = ddc_pkg::SRC_HOST;
                8'd2: rb = r_is_set ? ddc_pkg::LEN_SET_REQ : ddc_pkg::LEN_GET_REQ;
                8'd3: rb = r_is_set ? ddc_pkg::OP_SET_REQ : ddc_pkg::OP_GET_REQ;
                8'd4: rb = r_code;
                8'd5: rb = r_val[15:8];
                default: rb = r_val[7:0];
            endcase
            if (n_stage == ddc_pkg::S_SEND) begin
                b = ((n_idx + 8'd1) >= req_len) ? n_chk : rb;
                n_chk = n_chk ^ b;
            end else if (n_stage == ddc_pkg::S_RADDR) b = ddc_pkg::ADDR_RD;
            bnew = b;
            n_shift = bnew; n_bit = '0; n_phase = ddc_pkg::P_B_LO;
        end
        if (n_done) begin n_phase = ddc_pkg::P_IDLE; n_stage = ddc_pkg::S_NONE; end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ddc_pkg::P_IDLE; r_stage <= ddc_pkg::S_NONE;
            r_bit <= '0; r_idx <= '0; r_shift <= '0; r_wait <= '0; r_att <= '0;
            r_chk <= '0; r_rlen <= '0; r_is_set <= 1'b0; r_code <= '0; r_val <= '0;
            r_clr <= '0; r_res <= '0; r_len_byte <= '0;
            o_out <= '0;
        end else if (i_step) begin
            r_phase <= n_phase; r_stage <= n_stage; r_bit <= n_bit; r_idx <= n_idx;
            r_shift <= n_shift; r_wait <= n_wait; r_att <= n_att; r_chk <= n_chk;
            r_rlen <= n_rlen; r_is_set <= n_is_set; r_code <= n_code; r_val <= n_val;
            r_clr <= n_clr; r_res <= n_res; r_len_byte <= n_len_byte;
            o_out.scl_low <= (n_phase == ddc_pkg::P_ST_C || n_phase == ddc_pkg::P_SP_A ||
                              n_phase == ddc_pkg::P_CL_LO || n_phase == ddc_pkg::P_B_LO);
            o_out.sda_low <= (n_phase == ddc_pkg::P_ST_B || n_phase == ddc_pkg::P_SP_B ||
                              n_phase == ddc_pkg::P_ST_C || n_phase == ddc_pkg::P_SP_A) ||
                             ((n_phase == ddc_pkg::P_B_LO || n_phase == ddc_pkg::P_B_HI) &&
                              ((n_bit < 4'd8) ? !n_shift[7] :
                               (n_stage == ddc_pkg::S_READ &&
                                !((n_idx >= 8'd2) &&
                                  (n_idx == {1'b0, n_len_byte[6:0]} + 8'd2)))));
            o_out.busy <= (n_phase != ddc_pkg::P_IDLE);
            o_out.done <= n_done;
            o_out.res  <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && store_we) r_store[store_wa] <= r_shift;
    end

    `DDC_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, i_step && n_done,
                     !o_out.busy && r_phase == ddc_pkg::P_IDLE)
    `DDC_ASSERT_IMP(a_done_not_busy, i_clk, i_rst_n, o_out.done, !o_out.busy)
    `DDC_ASSERT_IMP(a_bit_range, i_clk, i_rst_n, 1'b1, r_bit <= 4'd8)
endmodule

// ===== hdl/ddc_ci_vcp_i2c_master.sv =====
// One result per tick, registered when the tick is accepted.
// Throughput: one tick per cycle while the output is taken; a new transaction enters
// only when the result register is empty or is taken in the same cycle.
// Reset (i_rst_n low, synchronous) returns to idle with config at 400/200/3.
module ddc_ci_vcp_i2c_master #(
    parameter int unsigned REPLY_BYTES  = 16,
    parameter int unsigned CLEAR_PULSES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode[1:0], scl_in, sda_in, vcp_code[7:0], set_value[15:0]
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // scl_drive_low, sda_drive_low, busy_res, done_res, status[1:0],
    // current_value[15:0], maximum_value[15:0], momentary
    output logic [39:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    logic [15:0] stretch_limit, gap_ticks;
    logic [2:0]  max_attempts;
    logic        step;
    logic        r_valid;
    ddc_pkg::t_tick tick;
    ddc_pkg::t_out  eout;

    ddc_cfg_regs u_cfg (
        .i_clk, .i_rst_n, .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_stretch_limit(stretch_limit), .o_gap_ticks(gap_ticks),
        .o_max_attempts(max_attempts)
    );

    assign tick.mode  = s_axis_tdata[1:0];
    assign tick.scl   = s_axis_tdata[2];
    assign tick.sda   = s_axis_tdata[3];
    assign tick.code  = s_axis_tdata[11:4];
    assign tick.value = s_axis_tdata[27:12];

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign step = s_axis_tvalid && s_axis_tready;

    ddc_engine #(.REPLY_BYTES(REPLY_BYTES), .CLEAR_PULSES(CLEAR_PULSES)) u_eng (
        .i_clk, .i_rst_n, .i_step(step), .i_tick(tick),
        .i_stretch_limit(stretch_limit), .i_gap_ticks(gap_ticks),
        .i_max_attempts(max_attempts), .o_out(eout)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (s_axis_tready) r_valid <= s_axis_tvalid;
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata = {1'b0, eout.res.mom, eout.res.maxv, eout.res.cur,
                           eout.res.status, eout.done, eout.busy, eout.sda_low,
                           eout.scl_low};
endmodule
